// File: src/shared_exclusive_lock_table_macros.svh
// Assertion macros shared by the lock table RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH

// Property checked on every rising edge outside reset
`define SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define SLC_ASSERT_NEVER(lbl, cond, msg) \
  `SLC_ASSERT(lbl, !(cond), msg)

`endif

// File: src/slc_pkg.sv
// Package for the shared/exclusive lock table: sizes, codes, entry layout,
// controller states and the control/status structs. No dependencies.
package slc_pkg;

  // Table size and derived widths
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned CNT_W   = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e;

  // Acquire outcome codes
  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_DRAIN  = 2'd2,
    S_COMMIT = 2'd3
  } state_e;

  // One table entry as stored in the RAM (valid bit lives in flops)
  typedef struct packed {
    logic [ID_W-1:0] tx;
    logic [ID_W-1:0] obj;
    logic [ID_W-1:0] row_key;
    logic            excl;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic rd;      // read entry at scan index, advance
    logic commit;  // apply table update, load result register
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index is at the last entry
  } stat_t;

endpackage

// File: src/slc_if.sv
// Valid/ready channel interfaces for the lock table request and response.
// No dependencies.
interface slc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] tx;
  logic [63:0] object;
  logic [63:0] row_key;
  logic        want_exclusive;

  modport source (output valid, cmd, tx, object, row_key, want_exclusive, input ready);
  modport sink   (input valid, cmd, tx, object, row_key, want_exclusive, output ready);
endinterface

interface slc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       owned;
  logic [4:0] released_count;

  modport source (output valid, status, owned, released_count, input ready);
  modport sink   (input valid, status, owned, released_count, output ready);
endinterface

// File: src/shared_exclusive_lock_table.sv
// Shared/exclusive row lock table, top level.
// Request channel in, response channel out (one response per request).
// Commands: acquire (status), release all of a transaction (released_count),
// query ownership (owned); fields a command does not produce read zero.
// Each request scans every table entry once through the entry RAM, one entry
// per cycle; the single read port of that RAM sets the pace.
// The block takes no new request until the current one has committed its
// result. One request is in flight at a time.
// Reset clears all valid bits at once, so the table is empty and the block
// takes requests in the first cycle after reset.
// A finished response waits in the output register until taken; the next
// request is still accepted and scanned meanwhile, and its commit holds until
// the output register is free.
// Depends on slc_pkg, slc_if, slc_ctrl and slc_dp.
module shared_exclusive_lock_table
  import slc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  slc_req_if.sink   req_i,
  slc_rsp_if.source rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  slc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  slc_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .req_cmd_i            (req_i.cmd),
    .req_tx_i             (req_i.tx),
    .req_object_i         (req_i.object),
    .req_row_key_i        (req_i.row_key),
    .req_want_exclusive_i (req_i.want_exclusive),
    .ctrl_i               (ctrl),
    .stat_o               (stat),
    .rsp_status_o         (rsp_o.status),
    .rsp_owned_o          (rsp_o.owned),
    .rsp_released_count_o (rsp_o.released_count)
  );

endmodule

// File: src/slc_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module slc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/slc_dp.sv
// Lock table datapath: request registers, valid bits, entry RAM, scan
// evaluation and result registers. Depends on slc_pkg and slc_ram.
module slc_dp
  import slc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       req_cmd_i,
  input  logic [ID_W-1:0]  req_tx_i,
  input  logic [ID_W-1:0]  req_object_i,
  input  logic [ID_W-1:0]  req_row_key_i,
  input  logic             req_want_exclusive_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  output logic [1:0]       rsp_status_o,
  output logic             rsp_owned_o,
  output logic [CNT_W-1:0] rsp_released_count_o
);

  // Captured request
  cmd_e            cmd_q;
  logic [ID_W-1:0] tx_q, obj_q, key_q;
  logic            excl_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_e'(req_cmd_i);
      tx_q   <= req_tx_i;
      obj_q  <= req_object_i;
      key_q  <= req_row_key_i;
      excl_q <= req_want_exclusive_i;
    end
  end

  // Scan index and its registered copy, aligned with RAM read data
  logic [IDX_W-1:0] idx_q, eidx_q;
  logic             eval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      eidx_q <= '0;
      eval_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        idx_q <= '0;
      end else if (ctrl_i.rd) begin
        idx_q <= idx_q + 1'b1;
      end
      eval_q <= ctrl_i.rd;
      eidx_q <= idx_q;
    end
  end

  assign stat_o.scan_last = (idx_q == IDX_W'(ENTRIES - 1));

  // Entry storage
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                    rd_entry;
  entry_t                    wr_entry;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;

  slc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ctrl_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Entry valid flags
  logic valid_q [ENTRIES];

  // Per-entry compare of the word just read
  logic ent_valid, ent_tx_eq, ent_match;
  assign ent_valid = valid_q[eidx_q];
  assign ent_tx_eq = (rd_entry.tx == tx_q);
  assign ent_match = (rd_entry.obj == obj_q) && (rd_entry.row_key == key_q);

  // Scan accumulators
  logic             conflict_q, own_q, free_q, hit_q;
  logic [IDX_W-1:0] own_idx_q, free_idx_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      conflict_q <= 1'b0;
      own_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_q      <= 1'b0;
      cnt_q      <= '0;
    end else if (eval_q) begin
      case (cmd_q)
        CMD_ACQUIRE: begin
          if (!ent_valid && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= eidx_q;
          end
          if (ent_valid && ent_match) begin
            if (!ent_tx_eq && (rd_entry.excl || excl_q)) begin
              conflict_q <= 1'b1;
            end else if (ent_tx_eq && !own_q) begin
              own_q     <= 1'b1;
              own_idx_q <= eidx_q;
            end
          end
        end
        CMD_RELEASE: begin
          if (ent_valid && ent_tx_eq && (cnt_q != CNT_MAX)) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        CMD_QUERY: begin
          if (ent_valid && ent_tx_eq && ent_match) begin
            hit_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Acquire outcome and table update
  status_e acq_status;
  logic    acq_ok;

  always_comb begin
    if (conflict_q) begin
      acq_status = ST_CONFLICT;
    end else if (own_q || free_q) begin
      acq_status = ST_GRANTED;
    end else begin
      acq_status = ST_FULL;
    end
  end

  assign acq_ok    = ctrl_i.commit && (cmd_q == CMD_ACQUIRE) && !conflict_q;
  // An own entry matches tx/object/key, so rewriting it only changes the mode
  assign ram_we    = acq_ok && (own_q ? excl_q : free_q);
  assign ram_waddr = own_q ? own_idx_q : free_idx_q;
  assign wr_entry  = '{tx: tx_q, obj: obj_q, row_key: key_q, excl: excl_q};

  // Valid bits: cleared by release during the scan, set by a new allocation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(ENTRIES); i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      if (eval_q && (cmd_q == CMD_RELEASE) && ent_valid && ent_tx_eq) begin
        valid_q[eidx_q] <= 1'b0;
      end
      if (acq_ok && !own_q && free_q) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Result register; fields a command does not produce read zero
  status_e          status_q;
  logic             owned_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      status_q <= (cmd_q == CMD_ACQUIRE) ? acq_status : ST_GRANTED;
      owned_q  <= (cmd_q == CMD_QUERY) && hit_q;
      count_q  <= (cmd_q == CMD_RELEASE) ? cnt_q : '0;
    end
  end

  assign rsp_status_o         = status_q;
  assign rsp_owned_o          = owned_q;
  assign rsp_released_count_o = count_q;

endmodule

// File: src/slc_ctrl.sv
// Lock table controller: sequences accept, entry scan, drain and commit,
// and owns the response valid flag. Depends on slc_pkg and the macro header.
`include "shared_exclusive_lock_table_macros.svh"

module slc_ctrl
  import slc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  // State and response flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // wait until the result slot is free or being emptied
        if (!rsp_valid_q || rsp_ready_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response valid: set on commit, cleared on transfer
  always_comb begin
    if (ctrl_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `SLC_ASSERT_NEVER(a_commit_overwrite, ctrl_o.commit && rsp_valid_q && !rsp_ready_i,
                    "commit would overwrite an untaken result")
  `SLC_ASSERT(a_accept_starts_scan, (state_q == S_IDLE) && req_valid_i |=> state_q == S_SCAN,
              "accepted request did not start a scan")
  `SLC_ASSERT(a_scan_ends_drain, (state_q == S_SCAN) && stat_i.scan_last |=> state_q == S_DRAIN,
              "scan did not stop at the last entry")
  `SLC_ASSERT(a_commit_sets_valid, ctrl_o.commit |=> rsp_valid_q,
              "commit did not raise response valid")

endmodule
